// ----- hdl/mmmw_pkg.sv -----
`timescale 1ns / 1ps

package mmmw_pkg;

    localparam int LOAD_W = 17;

    localparam logic [1:0] REQ_STEP      = 2'd0;
    localparam logic [1:0] REQ_LOAD_CELL = 2'd1;
    localparam logic [1:0] REQ_LOAD_MOVE = 2'd2;

    localparam logic [1:0] KIND_STEP   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam logic [1:0] CFG_CELL_COUNT    = 2'd0;
    localparam logic [1:0] CFG_BURN_STEPS    = 2'd1;
    localparam logic [1:0] CFG_THIN_INTERVAL = 2'd2;
    localparam logic [1:0] CFG_SAMPLE_LIMIT  = 2'd3;

    typedef struct packed {
        logic load_cell;
        logic load_move;
        logic start;
        logic report_done;
        logic issue;
        logic check;
        logic commit;
        logic restart;
        logic update;
        logic emit_first;
        logic emit_next;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       burn_active;
        logic       chain_done;
        logic       emit_due;
        logic       issue_done;
        logic       pipe_busy;
        logic       fail;
        logic       last_cell;
    } t_dp_sts;

endpackage

// ----- hdl/mmmw_ram.sv -----
`timescale 1ns / 1ps

module mmmw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/mmmw_ctrl.sv -----
`timescale 1ns / 1ps

module mmmw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  mmmw_pkg::t_dp_sts i_sts,
    output mmmw_pkg::t_dp_cmd o_cmd
);

    import mmmw_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_COMMIT = 6'b000100,
        ST_UPDATE = 6'b001000,
        ST_REPORT = 6'b010000,
        ST_EMIT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    unique case (i_sts.req_type)
                        REQ_LOAD_CELL: begin
                            o_cmd.load_cell = 1'b1;
                        end
                        REQ_LOAD_MOVE: begin
                            o_cmd.load_move = 1'b1;
                        end
                        REQ_STEP: begin
                            o_cmd.start = 1'b1;
                            if (!i_sts.burn_active && i_sts.chain_done) begin
                                o_cmd.report_done = 1'b1;
                                n_state           = ST_REPORT;
                            end else begin
                                n_state = ST_CHECK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (!i_sts.issue_done && !i_sts.fail) begin
                    o_cmd.issue = 1'b1;
                end else if (!i_sts.pipe_busy) begin
                    if (i_sts.fail) begin
                        n_state = ST_UPDATE;
                    end else begin
                        o_cmd.restart = 1'b1;
                        n_state       = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (!i_sts.issue_done) begin
                    o_cmd.issue = 1'b1;
                end else if (!i_sts.pipe_busy) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                if (!i_sts.burn_active && i_sts.emit_due) begin
                    o_cmd.emit_first = 1'b1;
                    n_state          = ST_EMIT;
                end else begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    if (i_sts.last_cell) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/mmmw_dp.sv -----
`timescale 1ns / 1ps

module mmmw_dp #(
    parameter int MAX_CELLS = 64,
    parameter int MAX_MOVES = 256,
    parameter int CELL_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic [31:0]       i_s_tdata,
    input  logic [1:0]        i_s_tuser,
    input  mmmw_pkg::t_dp_cmd i_cmd,
    output mmmw_pkg::t_dp_sts o_sts,
    output logic [87:0]       o_m_tdata,
    output logic [1:0]        o_m_tuser,
    output logic              o_m_tlast
);

    import mmmw_pkg::*;

    localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int KW    = $clog2(MAX_CELLS + 1);
    localparam int MVD   = MAX_MOVES * MAX_CELLS;
    localparam int MVAW  = (MVD > 1) ? $clog2(MVD) : 1;
    localparam int SW    = ((CELL_BITS > LOAD_W) ? CELL_BITS : LOAD_W) + 2;
    localparam logic signed [SW-1:0] CMAX = SW'({CELL_BITS{1'b1}});

    // input fields
    logic [7:0]        w_mi;
    logic [5:0]        w_ci;
    logic [LOAD_W-1:0] w_lv_raw;
    assign w_mi     = i_s_tdata[7:0];
    assign w_ci     = i_s_tdata[13:8];
    assign w_lv_raw = i_s_tdata[30:14];

    // configuration
    logic [6:0]  r_cell_count;
    logic [31:0] r_burn_steps;
    logic [15:0] r_thin;
    logic [31:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= 7'd1;
            r_burn_steps <= 32'd0;
            r_thin       <= 16'd1;
            r_limit      <= 32'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CELL_COUNT:    r_cell_count <= i_cfg_data[6:0];
                CFG_BURN_STEPS:    r_burn_steps <= i_cfg_data;
                CFG_THIN_INTERVAL: r_thin       <= i_cfg_data[15:0];
                CFG_SAMPLE_LIMIT:  r_limit      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic [KW-1:0] w_n;
    logic [15:0]   w_thin;
    always_comb begin
        if (r_cell_count == 7'd0) begin
            w_n = KW'(1);
        end else if (32'(r_cell_count) > 32'(MAX_CELLS)) begin
            w_n = KW'(MAX_CELLS);
        end else begin
            w_n = KW'(r_cell_count);
        end
        w_thin = (r_thin == 16'd0) ? 16'd1 : r_thin;
    end

    // chain counters
    logic [31:0] r_burn_cnt;
    logic [15:0] r_phase;
    logic [31:0] r_kept;
    logic [31:0] r_acc_cnt;
    logic [31:0] r_step_cnt;
    logic [15:0] w_phase_inc;
    logic        w_burn_active;
    logic        w_emit_due;

    assign w_phase_inc   = r_phase + 16'd1;
    assign w_burn_active = r_burn_cnt < r_burn_steps;
    assign w_emit_due    = w_phase_inc >= w_thin;

    // sequencing
    logic [KW-1:0]   r_k;
    logic            r_pipe_vld;
    logic [AW-1:0]   r_pipe_k;
    logic            r_fail;
    logic [MVAW-1:0] r_move_base;
    logic [1:0]      r_kind;
    logic            r_acc;

    // rams
    logic                   w_cell_we;
    logic [AW-1:0]          w_cell_waddr;
    logic [CELL_BITS-1:0]   w_cell_wdata;
    logic                   w_cell_re;
    logic [AW-1:0]          w_cell_raddr;
    logic [CELL_BITS-1:0]   w_cell_rdata;
    logic                   w_move_we;
    logic [MVAW-1:0]        w_move_waddr;
    logic [LOAD_W-1:0]      w_move_rdata;

    logic                   w_ci_ok;
    logic                   w_mi_ok;
    logic signed [SW-1:0]   w_lv;
    logic signed [SW-1:0]   w_sat;
    logic signed [SW-1:0]   w_cell_s;
    logic signed [SW-1:0]   w_move_s;
    logic signed [SW-1:0]   w_sum;
    logic                   w_oor;

    assign w_ci_ok  = 32'(w_ci) < 32'(MAX_CELLS);
    assign w_mi_ok  = 32'(w_mi) < 32'(MAX_MOVES);
    assign w_lv     = SW'($signed(w_lv_raw));
    assign w_sat    = (w_lv < 0) ? '0 : ((w_lv > CMAX) ? CMAX : w_lv);
    assign w_cell_s = SW'(w_cell_rdata);
    assign w_move_s = SW'($signed(w_move_rdata));
    assign w_sum    = w_cell_s + w_move_s;
    assign w_oor    = (w_sum < 0) || (w_sum > CMAX);

    assign w_cell_we    = (i_cmd.load_cell && w_ci_ok) || (i_cmd.commit && r_pipe_vld);
    assign w_cell_waddr = i_cmd.load_cell ? AW'(w_ci) : r_pipe_k;
    assign w_cell_wdata = i_cmd.load_cell ? CELL_BITS'(w_sat) : CELL_BITS'(w_sum);
    assign w_cell_re    = i_cmd.issue || i_cmd.emit_first || i_cmd.emit_next;

    always_comb begin
        if (i_cmd.emit_first) begin
            w_cell_raddr = '0;
        end else if (i_cmd.emit_next) begin
            w_cell_raddr = AW'(r_k + KW'(1));
        end else begin
            w_cell_raddr = r_k[AW-1:0];
        end
    end

    assign w_move_we    = i_cmd.load_move && w_mi_ok && w_ci_ok;
    assign w_move_waddr = MVAW'(32'(w_mi) * 32'(MAX_CELLS) + 32'(w_ci));

    mmmw_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (MAX_CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_cell_we),
        .i_waddr (w_cell_waddr),
        .i_wdata (w_cell_wdata),
        .i_re    (w_cell_re),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_cell_rdata)
    );

    mmmw_ram #(
        .WIDTH (LOAD_W),
        .DEPTH (MVD)
    ) u_move_ram (
        .i_clk   (i_clk),
        .i_we    (w_move_we),
        .i_waddr (w_move_waddr),
        .i_wdata (w_lv_raw),
        .i_re    (i_cmd.issue),
        .i_raddr (r_move_base + MVAW'(r_k)),
        .o_rdata (w_move_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k        <= '0;
            r_pipe_vld <= 1'b0;
            r_fail     <= 1'b0;
        end else begin
            r_pipe_vld <= i_cmd.issue;
            if (i_cmd.start || i_cmd.restart || i_cmd.emit_first) begin
                r_k <= '0;
            end else if (i_cmd.issue || i_cmd.emit_next) begin
                r_k <= r_k + KW'(1);
            end
            if (i_cmd.start) begin
                r_fail <= !w_mi_ok;
            end else if (i_cmd.check && r_pipe_vld && w_oor) begin
                r_fail <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe_k <= r_k[AW-1:0];
        if (i_cmd.start) begin
            r_move_base <= MVAW'(32'(w_mi) * 32'(MAX_CELLS));
        end
        if (i_cmd.report_done) begin
            r_kind <= KIND_DONE;
            r_acc  <= 1'b0;
        end else if (i_cmd.update) begin
            r_acc <= !r_fail;
            if (!w_burn_active && w_emit_due) begin
                r_kind <= KIND_SAMPLE;
            end else begin
                r_kind <= KIND_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burn_cnt <= '0;
            r_phase    <= '0;
            r_kept     <= '0;
            r_acc_cnt  <= '0;
            r_step_cnt <= '0;
        end else if (i_cmd.update) begin
            if (w_burn_active) begin
                r_burn_cnt <= r_burn_cnt + 32'd1;
            end else begin
                if (r_step_cnt != '1) begin
                    r_step_cnt <= r_step_cnt + 32'd1;
                end
                if (!r_fail && r_acc_cnt != '1) begin
                    r_acc_cnt <= r_acc_cnt + 32'd1;
                end
                if (w_emit_due) begin
                    r_phase <= '0;
                    r_kept  <= r_kept + 32'd1;
                end else begin
                    r_phase <= w_phase_inc;
                end
            end
        end
    end

    always_comb begin
        o_sts.req_type    = i_s_tuser;
        o_sts.burn_active = w_burn_active;
        o_sts.chain_done  = r_kept >= r_limit;
        o_sts.emit_due    = w_emit_due;
        o_sts.issue_done  = r_k == w_n;
        o_sts.pipe_busy   = r_pipe_vld;
        o_sts.fail        = r_fail;
        o_sts.last_cell   = r_k == (w_n - KW'(1));
    end

    logic w_sample;
    assign w_sample = r_kind == KIND_SAMPLE;

    assign o_m_tuser = r_kind;
    assign o_m_tlast = w_sample ? o_sts.last_cell : 1'b1;
    assign o_m_tdata = {1'b0, r_step_cnt, r_acc_cnt,
                        w_sample ? 16'(w_cell_rdata) : 16'd0,
                        w_sample ? 6'(r_k) : 6'd0,
                        r_acc};

endmodule

// ----- hdl/markov_move_metropolis_walker.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake               payload
// s stream  in   i_s_tvalid/o_s_tready   tuser req_type; tdata move, cell index, load value
// m stream  out  o_m_tvalid/i_m_tready   tuser result_kind; tlast last; tdata see port
// cfg write in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// a load is taken in idle and leaves the block ready; a step runs a check pass and then a
// commit pass over the cell ram, one cell per cycle, each followed by a pipeline drain;
// then it reports; a kept sample emits every cell, a finished chain only a done report
// a rejected step ends its check pass early and skips the commit pass
// reset is synchronous; ram contents are not cleared
// output stalls hold the step; a new item is taken only after the last result

module markov_move_metropolis_walker #(
    parameter int MAX_CELLS = 64,
    parameter int MAX_MOVES = 256,
    parameter int CELL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // move_index, cell_index, load_value
    input  logic [1:0]  i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // accepted, out_cell_index, out_cell_value,
                                     // accept_total, step_total
    output logic [1:0]  o_m_tuser,   // result_kind
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    import mmmw_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    mmmw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mmmw_dp #(
        .MAX_CELLS (MAX_CELLS),
        .MAX_MOVES (MAX_MOVES),
        .CELL_BITS (CELL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_m_tvalid && o_s_tready))
        else $error("result pending while input ready");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser != REQ_STEP) |=> o_s_tready)
        else $error("load transaction left idle");

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == REQ_STEP) |=> !o_s_tready)
        else $error("step transaction did not start work");

    a_done_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_DONE) |-> (o_m_tlast && !o_m_tdata[0]))
        else $error("finished chain report malformed");
`endif

endmodule

// ----- sim/walker_checker.sv -----
`timescale 1ns / 1ps

module walker_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [87:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    import mmmw_pkg::*;

    localparam int MAX_CELLS = 64;
    localparam int CELL_MAX  = 65535;

    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic [5:0]  cell_idx;
        logic [15:0] cell_val;
        logic        last;
        logic [31:0] acc_total;
        logic [31:0] step_total;
    } t_walk_result;

    logic [6:0]  cfg_ncells;
    logic [31:0] cfg_burn;
    logic [15:0] cfg_thin;
    logic [31:0] cfg_limit;

    logic [15:0]        cell_cnt [MAX_CELLS];
    logic signed [16:0] move_tab [256][MAX_CELLS];
    logic [31:0]        burn_seen;
    logic [15:0]        thin_pos;
    logic [31:0]        kept_seen;
    logic [31:0]        accept_total;
    logic [31:0]        step_total;

    t_walk_result pending_results[$];
    t_walk_result want;
    t_walk_result got;
    int           fail_total = 0;

    function automatic logic apply_move(input logic [7:0] mi, input int n);
        int p;
        for (int k = 0; k < n; k++) begin
            p = int'(cell_cnt[k]) + int'(move_tab[mi][k]);
            if (p < 0 || p > CELL_MAX) return 1'b0;
        end
        for (int k = 0; k < n; k++) begin
            p = int'(cell_cnt[k]) + int'(move_tab[mi][k]);
            cell_cnt[k] = p[15:0];
        end
        return 1'b1;
    endfunction

    task automatic queue_result(input logic [1:0] kind, input logic acc,
                                input logic [5:0] idx, input logic [15:0] val,
                                input logic last);
        pending_results.push_back({kind, acc, idx, val, last, accept_total, step_total});
    endtask

    task automatic predict_walk(input logic [1:0] req, input logic [7:0] mi,
                                input logic [5:0] ci, input logic signed [16:0] lv);
        int          n;
        int          v;
        logic        acc;
        logic [15:0] thin_eff;
        n = (cfg_ncells == 0) ? 1 : ((cfg_ncells > MAX_CELLS) ? MAX_CELLS : int'(cfg_ncells));
        thin_eff = (cfg_thin == 0) ? 16'd1 : cfg_thin;
        case (req)
            REQ_LOAD_CELL: begin
                v = (lv < 0) ? 0 : int'(lv);
                if (v > CELL_MAX) v = CELL_MAX;
                cell_cnt[ci] = v[15:0];
            end
            REQ_LOAD_MOVE: begin
                move_tab[mi][ci] = lv;
            end
            REQ_STEP: begin
                if (burn_seen < cfg_burn) begin
                    acc = apply_move(mi, n);
                    burn_seen++;
                    queue_result(KIND_STEP, acc, '0, '0, 1'b1);
                end else if (kept_seen >= cfg_limit) begin
                    queue_result(KIND_DONE, 1'b0, '0, '0, 1'b1);
                end else begin
                    acc = apply_move(mi, n);
                    if (step_total != '1) step_total++;
                    if (acc && accept_total != '1) accept_total++;
                    thin_pos = thin_pos + 16'd1;
                    if (thin_pos >= thin_eff) begin
                        thin_pos = '0;
                        kept_seen++;
                        for (int k = 0; k < n; k++)
                            queue_result(KIND_SAMPLE, acc, k[5:0], cell_cnt[k], k == n - 1);
                    end else begin
                        queue_result(KIND_STEP, acc, '0, '0, 1'b1);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ncells   = 7'd1;
            cfg_burn     = '0;
            cfg_thin     = 16'd1;
            cfg_limit    = 32'd1;
            burn_seen    = '0;
            thin_pos     = '0;
            kept_seen    = '0;
            accept_total = '0;
            step_total   = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CELL_COUNT:    cfg_ncells = i_cfg_data[6:0];
                    CFG_BURN_STEPS:    cfg_burn   = i_cfg_data;
                    CFG_THIN_INTERVAL: cfg_thin   = i_cfg_data[15:0];
                    CFG_SAMPLE_LIMIT:  cfg_limit  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_walk(i_s_tuser, i_s_tdata[7:0], i_s_tdata[13:8], i_s_tdata[30:14]);
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tuser, i_m_tdata[0], i_m_tdata[6:1], i_m_tdata[22:7], i_m_tlast,
                       i_m_tdata[54:23], i_m_tdata[86:55]};
                if (pending_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(got.kind));
                    check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                    check_field("out_cell_index", 32'(want.cell_idx), 32'(got.cell_idx));
                    check_field("out_cell_value", 32'(want.cell_val), 32'(got.cell_val));
                    check_field("last", 32'(want.last), 32'(got.last));
                    check_field("accept_total", want.acc_total, got.acc_total);
                    check_field("step_total", want.step_total, got.step_total);
                end
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import mmmw_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int QUIET_CYCLES = 220;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int fail_count;
    int results_left;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    logic [6:0]  cur_cells = 7'd1;
    logic [63:0] cell_known = '0;
    logic [63:0] move_known [256];

    initial begin
        foreach (move_known[r]) move_known[r] = '0;
    end

    always #6 clk = ~clk;

    always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    markov_move_metropolis_walker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    walker_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (results_left)
    );

    function automatic int live_cells();
        if (cur_cells == 0) return 1;
        if (cur_cells > 64) return 64;
        return int'(cur_cells);
    endfunction

    function automatic logic signed [16:0] rand_cell();
        case ($urandom_range(0, 9))
            0:       return 17'($urandom);
            1:       return 17'(65535 - $urandom_range(0, 20));
            2:       return 17'($urandom_range(0, 3));
            default: return 17'($urandom_range(20, 2000));
        endcase
    endfunction

    function automatic logic signed [16:0] rand_move();
        case ($urandom_range(0, 9))
            0:       return 17'($urandom);
            1:       return 17'(int'($urandom_range(0, 40)) - 20);
            default: return 17'(int'($urandom_range(0, 4)) - 2);
        endcase
    endfunction

    function automatic logic [7:0] pick_row(input int top_row);
        return 8'($urandom_range(0, top_row));
    endfunction

    task automatic set_idle(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    task automatic send(input logic [1:0] req, input logic [7:0] mi, input logic [5:0] ci,
                        input logic signed [16:0] lv);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {1'b0, lv, ci, mi};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_left != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_CELL_COUNT) cur_cells = val[6:0];
        @(posedge clk);
    endtask

    task automatic load_cell(input logic [5:0] ci, input logic signed [16:0] val);
        send(REQ_LOAD_CELL, 8'($urandom), ci, val);
        cell_known[ci] = 1'b1;
    endtask

    task automatic load_move(input logic [7:0] row, input logic [5:0] ci,
                             input logic signed [16:0] val);
        send(REQ_LOAD_MOVE, row, ci, val);
        move_known[row][ci] = 1'b1;
    endtask

    // every cell and move entry a step reads must hold a loaded value
    task automatic step(input logic [7:0] row);
        int n = live_cells();
        for (int k = 0; k < n; k++) begin
            if (!cell_known[k]) load_cell(6'(k), rand_cell());
            if (!move_known[row][k]) load_move(row, 6'(k), rand_move());
        end
        send(REQ_STEP, row, 6'($urandom), 17'($urandom));
    endtask

    task automatic run_phase(input logic [6:0] cells, input logic [31:0] burn,
                             input logic [15:0] thin, input logic [31:0] limit,
                             input int items, input int top_row);
        int sel;
        settle();
        write_reg(CFG_CELL_COUNT, 32'(cells));
        write_reg(CFG_BURN_STEPS, burn);
        write_reg(CFG_THIN_INTERVAL, 32'(thin));
        write_reg(CFG_SAMPLE_LIMIT, limit);
        for (int i = 0; i < items; i++) begin
            if (i == items / 2) wait_results();
            sel = $urandom_range(0, 99);
            if (sel < 70)
                step(pick_row(top_row));
            else if (sel < 82)
                load_cell(6'($urandom_range(0, 63)), rand_cell());
            else if (sel < 94)
                load_move(8'($urandom), 6'($urandom_range(0, 63)), rand_move());
            else
                send(REQ_UNUSED, 8'($urandom), 6'($urandom), 17'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        set_idle(32, 61);

        // reset settings: one cell, no burn-in, every step kept, one sample
        send(REQ_UNUSED, 8'($urandom), 6'($urandom), 17'($urandom));
        load_cell(6'd0, 17'(-65536));
        load_cell(6'd63, 17'(65535));
        load_move(8'd255, 6'd63, 17'(-65536));
        load_move(8'd0, 6'd0, 17'(65535));
        step(8'd0);
        step(8'd0);

        // burn-in, zero thin interval, over-max and below-zero rejections
        settle();
        write_reg(CFG_CELL_COUNT, 32'd2);
        write_reg(CFG_THIN_INTERVAL, 32'd0);
        write_reg(CFG_SAMPLE_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_BURN_STEPS, 32'd2);
        load_cell(6'd1, 17'(5));
        load_move(8'd0, 6'd1, 17'(1));
        load_move(8'd1, 6'd0, 17'(-1));
        load_move(8'd1, 6'd1, 17'(-6));
        step(8'd1);
        step(8'd0);
        step(8'd1);
        load_move(8'd1, 6'd1, 17'(-5));
        step(8'd1);
        step(8'd255);

        run_phase(7'd4, 32'd10, 16'd3, 32'hFFFF_FFFF, 30, 3);
        run_phase(7'd0, 32'd0, 16'd1, 32'hFFFF_FFFF, 20, 3);
        set_idle(61, 32);
        run_phase(7'd64, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 30, 0);
        run_phase(7'd127, 32'd0, 16'd2, 32'hFFFF_FFFF, 20, 0);
        set_idle(0, 0);
        run_phase(7'd8, 32'hFFFF_FFFF, 16'd5, 32'hFFFF_FFFF, 20, 3);
        run_phase(7'd3, 32'd0, 16'd1, 32'd0, 15, 3);
        run_phase(7'd6, 32'd0, 16'd4, 32'hFFFF_FFFF, 45, 3);

        settle();
        if (fail_count == 0) begin
            $display("markov_move_metropolis_walker test passed");
        end else begin
            $display("markov_move_metropolis_walker test failed");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("markov_move_metropolis_walker test failed");
        $finish;
    end

endmodule
